@@ hdl/srlp_pkg.sv @@
// Package for the SMTP reply line parser: parse phase type, separator codes,
// character constants and the keyword lookup for the AUTH check.
// No dependencies.
package srlp_pkg;

   // default line limit, in bytes; a line closes at DefaultMaxLine-1 bytes, terminator included
   localparam int DefaultMaxLine = 1024;

   // width of the length and offset fields of a result
   localparam int LenOutW = 10;

   // parse phase of the current line
   typedef enum logic [1:0] {
      PH_CODE = 2'd0,
      PH_MSG  = 2'd1,
      PH_BAD  = 2'd2
   } phase_type;

   // separator codes as reported in separator_kind
   localparam logic [1:0] SEP_NONE  = 2'd0;
   localparam logic [1:0] SEP_DASH  = 2'd1;
   localparam logic [1:0] SEP_SPACE = 2'd2;

   // characters of interest
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_DASH  = 8'h2D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_LOW_A = 8'h61;
   localparam logic [7:0] CH_LOW_Z = 8'h7A;
   localparam logic [7:0] CASE_GAP = 8'h20;

   // keyword length and lookup, "AUTH " in upper case
   localparam logic [2:0] AUTH_LEN = 3'd5;

   function automatic logic [7:0] auth_char(input logic [2:0] idx);
      logic [7:0] ch;
      case (idx)
         3'd0: ch = 8'h41;
         3'd1: ch = 8'h55;
         3'd2: ch = 8'h54;
         3'd3: ch = 8'h48;
         3'd4: ch = 8'h20;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

@@ hdl/smtp_reply_line_parser.sv @@
// SMTP reply line parser, top level: per-byte line state and result register.
// Depends on srlp_pkg.
//
// Usage:
//  - req channel: one byte per beat (req_byte_in) with req_end_of_stream set
//    on the last byte of the stream. A beat is taken when req_valid is high
//    and req_stall is low.
//  - rsp channel: one beat per line. A line ends at a line feed, when it
//    reaches MAX_LINE-1 bytes, or at a byte flagged end of stream. The beat
//    carries the reply code, separator kind, AUTH flag, message offset,
//    content length (trailing LF or CRLF removed) and total length.
//  - throughput: one byte per cycle while req_stall is low. Each byte updates the line
//    state as it is taken; the only loop is that per-byte state update.
//  - result timing: the result of a line appears on rsp in the cycle after the byte
//    that ends the line is taken.
//  - stall: the result register holds one beat. While it is full and
//    rsp_stall is high, req_stall is raised and no byte is taken; a byte is
//    taken in the same cycle that the held beat leaves.
//  - reset: synchronous, active high; clears the line state and empties the
//    result register. The block takes bytes in the first cycle after reset.
module smtp_reply_line_parser #(
   parameter int MAX_LINE = srlp_pkg::DefaultMaxLine
) (
   input  logic                        clock,
   input  logic                        reset,
   // byte input
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [7:0]                  req_byte_in,
   input  logic                        req_end_of_stream,
   // line results
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_line_valid,
   output logic [9:0]                  rsp_reply_code,
   output logic [1:0]                  rsp_separator_kind,
   output logic                        rsp_is_auth,
   output logic [srlp_pkg::LenOutW-1:0] rsp_message_offset,
   output logic [srlp_pkg::LenOutW-1:0] rsp_content_length,
   output logic [srlp_pkg::LenOutW-1:0] rsp_total_length
);
   import srlp_pkg::*;

   localparam int LenW = $clog2(MAX_LINE);
   localparam int ExtW = (LenW > LenOutW) ? LenW : LenOutW;
   localparam logic [LenW-1:0] LAST_POS = LenW'(MAX_LINE - 1);

   // line state
   phase_type       phase_ff,       phase_in;
   logic [1:0]      digit_count_ff, digit_count_in;
   logic [9:0]      code_accum_ff,  code_accum_in;
   logic            cr_pending_ff,  cr_pending_in;
   logic [2:0]      match_index_ff, match_index_in;
   logic            match_ok_ff,    match_ok_in;
   logic [LenW-1:0] line_count_ff,  line_count_in;
   logic [1:0]      sep_seen_ff,    sep_seen_in;
   logic [LenW-1:0] msg_start_ff,   msg_start_in;
   logic            last_was_cr_ff, last_was_cr_in;

   // result register
   logic                rsp_valid_ff,   rsp_valid_in;
   logic                line_valid_ff,  line_valid_in;
   logic [9:0]          reply_code_ff,  reply_code_in;
   logic [1:0]          sep_kind_ff,    sep_kind_in;
   logic                is_auth_ff,     is_auth_in;
   logic [LenOutW-1:0]  msg_offset_ff,  msg_offset_in;
   logic [LenOutW-1:0]  content_len_ff, content_len_in;
   logic [LenOutW-1:0]  total_len_ff,   total_len_in;

   // per-byte working values
   logic            req_accept;
   logic            line_end;
   phase_type       phase_work;
   logic [1:0]      strip_cnt;
   logic [LenW-1:0] count_next;
   logic [LenW-1:0] content_cnt;
   logic [7:0]      byte_upper;
   logic [3:0]      digit_val;
   logic            end_valid;
   logic [ExtW-1:0] total_ext;
   logic [ExtW-1:0] content_ext;
   logic [ExtW-1:0] offset_ext;

   // handshake
   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;

   assign count_next = line_count_ff + LenW'(1);
   assign digit_val  = 4'(req_byte_in - CH_ZERO);

   // case folding for the keyword check
   always_comb begin
      if (req_byte_in inside {[CH_LOW_A:CH_LOW_Z]}) begin
         byte_upper = req_byte_in - CASE_GAP;
      end else begin
         byte_upper = req_byte_in;
      end
   end

   // next line state
   always_comb begin
      phase_work     = phase_ff;
      digit_count_in = digit_count_ff;
      code_accum_in  = code_accum_ff;
      cr_pending_in  = 1'b0;
      match_index_in = match_index_ff;
      match_ok_in    = match_ok_ff;
      sep_seen_in    = sep_seen_ff;
      msg_start_in   = msg_start_ff;
      strip_cnt      = 2'd0;
      line_end       = 1'b0;

      // a held carriage return only survives when a line feed follows
      if (cr_pending_ff && req_byte_in != CH_LF) begin
         phase_work = PH_BAD;
      end

      if (req_byte_in == CH_LF) begin
         strip_cnt = last_was_cr_ff ? 2'd2 : 2'd1;
         line_end  = 1'b1;
      end else begin
         case (phase_work)
            PH_CODE: begin
               if (req_byte_in inside {[CH_ZERO:CH_NINE]}) begin
                  if (digit_count_ff == 2'd3) begin
                     phase_work = PH_BAD;
                  end else begin
                     digit_count_in = digit_count_ff + 2'd1;
                     code_accum_in  = (code_accum_ff << 3) + (code_accum_ff << 1)
                                      + 10'(digit_val);
                  end
               end else if (req_byte_in == CH_DASH || req_byte_in == CH_SPACE) begin
                  sep_seen_in  = (req_byte_in == CH_DASH) ? SEP_DASH : SEP_SPACE;
                  msg_start_in = count_next;
                  phase_work   = PH_MSG;
               end else if (req_byte_in == CH_CR) begin
                  cr_pending_in = 1'b1;
               end else begin
                  phase_work = PH_BAD;
               end
            end
            PH_MSG: begin
               if (match_index_ff < AUTH_LEN) begin
                  if (byte_upper != auth_char(match_index_ff)) begin
                     match_ok_in = 1'b0;
                  end
                  match_index_in = match_index_ff + 3'd1;
               end
            end
            default: begin
            end
         endcase
      end

      last_was_cr_in = (req_byte_in == CH_CR);

      if (count_next >= LAST_POS || req_end_of_stream) begin
         line_end = 1'b1;
      end

      // a carriage return still held at the line end is not stripped and marks the line bad
      phase_in = phase_work;
      if (line_end && cr_pending_in) begin
         phase_in = PH_BAD;
      end

      line_count_in = count_next;
   end

   // result fields of the line that ends with this byte
   always_comb begin
      end_valid      = (phase_in == PH_CODE) || (phase_in == PH_MSG);
      content_cnt    = count_next - LenW'(strip_cnt);
      total_ext      = ExtW'(count_next);
      content_ext    = ExtW'(content_cnt);
      if (!end_valid) begin
         offset_ext = '0;
      end else if (sep_seen_in != SEP_NONE) begin
         offset_ext = ExtW'(msg_start_in);
      end else begin
         offset_ext = content_ext;
      end
      line_valid_in  = end_valid;
      reply_code_in  = code_accum_in;
      sep_kind_in    = end_valid ? sep_seen_in : SEP_NONE;
      is_auth_in     = end_valid && (phase_in == PH_MSG) && match_ok_in
                       && (match_index_in == AUTH_LEN);
      msg_offset_in  = offset_ext[LenOutW-1:0];
      content_len_in = content_ext[LenOutW-1:0];
      total_len_in   = total_ext[LenOutW-1:0];
   end

   // result beat occupancy
   always_comb begin
      if (req_accept && line_end) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // line state registers
   always_ff @(posedge clock) begin
      if (reset || (req_accept && line_end)) begin
         phase_ff       <= PH_CODE;
         digit_count_ff <= '0;
         code_accum_ff  <= '0;
         cr_pending_ff  <= 1'b0;
         match_index_ff <= '0;
         match_ok_ff    <= 1'b1;
         line_count_ff  <= '0;
         sep_seen_ff    <= SEP_NONE;
         msg_start_ff   <= '0;
         last_was_cr_ff <= 1'b0;
      end else if (req_accept) begin
         phase_ff       <= phase_in;
         digit_count_ff <= digit_count_in;
         code_accum_ff  <= code_accum_in;
         cr_pending_ff  <= cr_pending_in;
         match_index_ff <= match_index_in;
         match_ok_ff    <= match_ok_in;
         line_count_ff  <= line_count_in;
         sep_seen_ff    <= sep_seen_in;
         msg_start_ff   <= msg_start_in;
         last_was_cr_ff <= last_was_cr_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && line_end) begin
         line_valid_ff  <= line_valid_in;
         reply_code_ff  <= reply_code_in;
         sep_kind_ff    <= sep_kind_in;
         is_auth_ff     <= is_auth_in;
         msg_offset_ff  <= msg_offset_in;
         content_len_ff <= content_len_in;
         total_len_ff   <= total_len_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_line_valid     = line_valid_ff;
   assign rsp_reply_code     = reply_code_ff;
   assign rsp_separator_kind = sep_kind_ff;
   assign rsp_is_auth        = is_auth_ff;
   assign rsp_message_offset = msg_offset_ff;
   assign rsp_content_length = content_len_ff;
   assign rsp_total_length   = total_len_ff;

   // a line never grows past its limit before being closed
   assert property (@(posedge clock) disable iff (reset)
      line_count_ff < LAST_POS)
      else $error("line byte count passed the line limit");

   // a pending carriage return only exists in the code part
   assert property (@(posedge clock) disable iff (reset)
      cr_pending_ff |-> (phase_ff == PH_CODE))
      else $error("carriage return pending outside the code part");

   // the accumulated code stays a three digit decimal
   assert property (@(posedge clock) disable iff (reset)
      (code_accum_ff < 10'd1000) && (digit_count_ff != 2'd0 || code_accum_ff == 10'd0))
      else $error("reply code accumulator out of range");

   // an invalid line reports neither separator nor keyword
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !line_valid_ff) |-> (!is_auth_ff && sep_kind_ff == SEP_NONE))
      else $error("invalid line carries separator or keyword flag");

   // a line ending byte fills the result register on the next edge
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && line_end) |=> rsp_valid_ff)
      else $error("line end did not produce a result beat");

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for smtp_reply_line_parser: directed reply lines, then random
// well-formed, broken and noise lines, each result checked against a written-out or predicted one.
// Depends on srlp_pkg and the smtp_reply_line_parser RTL.
module testbench;
   import srlp_pkg::*;

   localparam int LineLimit = DefaultMaxLine;
   localparam int RandomBytes = 500;
   localparam int CycleLimit = 100000;
   localparam int DrainCycles = 8;
   localparam int HoldCycles = 300;
   localparam int HoldLine = 25;
   localparam int CutLine = 6;
   localparam int SpillBytes = 6;
   localparam int SteadyFirst = 8;
   localparam int SteadyLast = 16;
   localparam int ShownMismatches = 10;
   localparam int NoTail = -1;
   localparam int IdlePercent = 17;
   localparam logic [7:0] KeyChars [5] = '{"A", "U", "T", "H", " "};

   typedef struct packed {
      logic                line_valid;
      logic [9:0]          reply_code;
      logic [1:0]          separator_kind;
      logic                is_auth;
      logic [LenOutW-1:0]  message_offset;
      logic [LenOutW-1:0]  content_length;
      logic [LenOutW-1:0]  total_length;
   } line_result_type;

   typedef struct {
      string           text;
      int              tail;
      bit              eos;
      bit              typed;
      line_result_type want;
   } script_row_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } stream_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [7:0] req_byte_in = 8'h00;
   logic req_end_of_stream = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_line_valid;
   logic [9:0] rsp_reply_code;
   logic [1:0] rsp_separator_kind;
   logic rsp_is_auth;
   logic [LenOutW-1:0] rsp_message_offset;
   logic [LenOutW-1:0] rsp_content_length;
   logic [LenOutW-1:0] rsp_total_length;

   // line parse state of the local predictor
   phase_type  cur_phase;
   int         digit_total;
   logic [9:0] code_sum;
   bit         cr_waiting;
   int         key_pos;
   bit         key_hit;
   int         line_bytes;
   logic [1:0] sep_code;
   int         text_start;
   bit         prev_was_cr;

   line_result_type expected_lines[$];
   script_row_type  script[$];
   stream_beat_type burst[$];

   int  bytes_taken = 0;
   int  lines_checked = 0;
   int  invalid_lines = 0;
   int  auth_lines = 0;
   int  mismatch_count = 0;
   int  cycle_count = 0;
   int  hold_left = 0;
   bit  hold_done = 1'b0;
   bit  hold_request = 1'b0;
   bit  steady = 1'b0;

   smtp_reply_line_parser #(.MAX_LINE(LineLimit)) DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_byte_in        (req_byte_in),
      .req_end_of_stream  (req_end_of_stream),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_line_valid     (rsp_line_valid),
      .rsp_reply_code     (rsp_reply_code),
      .rsp_separator_kind (rsp_separator_kind),
      .rsp_is_auth        (rsp_is_auth),
      .rsp_message_offset (rsp_message_offset),
      .rsp_content_length (rsp_content_length),
      .rsp_total_length   (rsp_total_length)
   );

   always #6 clock = ~clock;

   // line parser predictor
   function void clear_line_state();
      cur_phase = PH_CODE;
      digit_total = 0;
      code_sum = '0;
      cr_waiting = 1'b0;
      key_pos = 0;
      key_hit = 1'b1;
      line_bytes = 0;
      sep_code = SEP_NONE;
      text_start = 0;
      prev_was_cr = 1'b0;
   endfunction

   function automatic logic [7:0] fold_upper(input logic [7:0] ch);
      if (ch >= CH_LOW_A && ch <= CH_LOW_Z) begin
         return ch - CASE_GAP;
      end
      return ch;
   endfunction

   // advance by one byte; returns 1 when the byte closes a line
   function automatic bit parse_byte(input logic [7:0] ch, input logic eos,
                                     output line_result_type res);
      int  pos;
      int  stripped;
      int  content;
      bit  closed;
      bit  ok;
      pos = line_bytes;
      stripped = 0;
      closed = 1'b0;
      res = '0;
      line_bytes++;

      // a held carriage return survives only in front of a line feed
      if (cr_waiting) begin
         cr_waiting = 1'b0;
         if (ch != CH_LF) cur_phase = PH_BAD;
      end

      if (ch == CH_LF) begin
         stripped = prev_was_cr ? 2 : 1;
         closed = 1'b1;
      end else if (cur_phase == PH_CODE) begin
         if (ch >= CH_ZERO && ch <= CH_NINE) begin
            if (digit_total >= 3) begin
               cur_phase = PH_BAD;
            end else begin
               digit_total++;
               code_sum = 10'(code_sum * 10 + (ch - CH_ZERO));
            end
         end else if (ch == CH_DASH || ch == CH_SPACE) begin
            sep_code = (ch == CH_DASH) ? SEP_DASH : SEP_SPACE;
            text_start = pos + 1;
            cur_phase = PH_MSG;
         end else if (ch == CH_CR) begin
            cr_waiting = 1'b1;
         end else begin
            cur_phase = PH_BAD;
         end
      end else if (cur_phase == PH_MSG) begin
         if (key_pos < 5) begin
            if (fold_upper(ch) != KeyChars[key_pos]) key_hit = 1'b0;
            key_pos++;
         end
      end

      prev_was_cr = (ch == CH_CR);
      if (line_bytes >= LineLimit - 1 || eos) closed = 1'b1;
      if (!closed) return 1'b0;

      if (cr_waiting) cur_phase = PH_BAD;
      ok = (cur_phase == PH_CODE || cur_phase == PH_MSG);
      content = line_bytes - stripped;
      res.line_valid = ok;
      res.reply_code = code_sum;
      res.separator_kind = ok ? sep_code : SEP_NONE;
      res.is_auth = ok && cur_phase == PH_MSG && key_hit && key_pos == 5;
      res.message_offset = LenOutW'(ok ? ((sep_code != SEP_NONE) ? text_start : content) : 0);
      res.content_length = LenOutW'(content);
      res.total_length = LenOutW'(line_bytes);
      clear_line_state();
      return 1'b1;
   endfunction

   function automatic string show_line(input line_result_type r);
      return $sformatf("ok=%0d code=%0d sep=%0d auth=%0d off=%0d content=%0d total=%0d",
                       r.line_valid, r.reply_code, r.separator_kind, r.is_auth,
                       r.message_offset, r.content_length, r.total_length);
   endfunction

   // directed rows with the line result written out
   function void add_row(input string text, input int tail, input bit eos, input logic ok,
                         input int code, input logic [1:0] sep, input logic auth,
                         input int off, input int content, input int total);
      script_row_type row;
      row.text = text;
      row.tail = tail;
      row.eos = eos;
      row.typed = 1'b1;
      row.want.line_valid = ok;
      row.want.reply_code = 10'(code);
      row.want.separator_kind = sep;
      row.want.is_auth = auth;
      row.want.message_offset = LenOutW'(off);
      row.want.content_length = LenOutW'(content);
      row.want.total_length = LenOutW'(total);
      script.push_back(row);
   endfunction

   // directed rows left to the predictor
   function void add_plain(input string text, input bit eos);
      script_row_type row;
      row.text = text;
      row.tail = NoTail;
      row.eos = eos;
      row.typed = 1'b0;
      row.want = '0;
      script.push_back(row);
   endfunction

   // offer one beat, idling at random first, and predict once it is taken
   task automatic send_byte(input logic [7:0] ch, input logic eos, input bit use_typed,
                            input line_result_type want);
      line_result_type res;
      while (!steady && $urandom_range(99) < IdlePercent) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_byte_in <= ch;
      req_end_of_stream <= eos;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_taken++;
      if (parse_byte(ch, eos, res)) begin
         expected_lines.push_back(use_typed ? want : res);
      end
   endtask

   function automatic logic [7:0] any_but_lf();
      logic [7:0] ch;
      ch = 8'($urandom_range(255));
      while (ch == CH_LF) ch = 8'($urandom_range(255));
      return ch;
   endfunction

   function automatic logic [7:0] printable();
      return 8'($urandom_range(8'h7E, 8'h20));
   endfunction

   function void push_beat(input logic [7:0] ch);
      burst.push_back('{data: ch, last: 1'b0});
   endfunction

   // build one random reply line into burst
   function void compose_reply(input int line_no);
      int kind;
      int pick;
      int count;
      logic [7:0] ch;
      burst.delete();
      if (line_no == CutLine) begin
         // well-formed line cut by length, a few bytes spilling into the next line
         push_beat("2");
         push_beat("5");
         push_beat("0");
         push_beat(CH_SPACE);
         repeat (LineLimit - 5 + SpillBytes) push_beat(printable());
         return;
      end
      kind = $urandom_range(99);
      if (kind < 70) begin
         // well-formed: digits, then mostly a separator and a message with a possible keyword
         pick = $urandom_range(9);
         count = (pick < 3) ? pick : 3;
         repeat (count) push_beat(8'(CH_ZERO + $urandom_range(9)));
         pick = $urandom_range(9);
         if (pick < 8) begin
            push_beat((pick < 4) ? CH_DASH : CH_SPACE);
            if ($urandom_range(1)) begin
               for (int i = 0; i < 5; i++) begin
                  ch = KeyChars[i];
                  if (i < 4 && $urandom_range(1)) ch = ch | CASE_GAP;
                  if ($urandom_range(7) == 0) ch = printable();
                  push_beat(ch);
               end
            end
            repeat ($urandom_range(12)) push_beat(printable());
         end
      end else if (kind < 85) begin
         // broken code part
         repeat ($urandom_range(5, 1)) begin
            pick = $urandom_range(5);
            if (pick < 3) push_beat(8'(CH_ZERO + $urandom_range(9)));
            else if (pick == 3) push_beat(CH_CR);
            else if (pick == 4) push_beat(any_but_lf());
            else push_beat(CH_SPACE);
         end
         repeat ($urandom_range(6)) push_beat(printable());
      end else begin
         // raw noise over all byte values
         repeat ($urandom_range(16, 1)) push_beat(8'($urandom_range(255)));
      end
      pick = $urandom_range(9);
      if (pick < 5) begin
         push_beat(CH_CR);
         push_beat(CH_LF);
      end else if (pick < 8) begin
         push_beat(CH_LF);
      end else if (burst.size() > 0) begin
         burst[burst.size() - 1].last = 1'b1;
      end else begin
         burst.push_back('{data: any_but_lf(), last: 1'b1});
      end
   endfunction

   // compare one result beat with the oldest expectation
   task automatic check_line();
      line_result_type want;
      line_result_type got;
      bit wrong;
      got.line_valid = rsp_line_valid;
      got.reply_code = rsp_reply_code;
      got.separator_kind = rsp_separator_kind;
      got.is_auth = rsp_is_auth;
      got.message_offset = rsp_message_offset;
      got.content_length = rsp_content_length;
      got.total_length = rsp_total_length;
      lines_checked++;
      if (!got.line_valid) invalid_lines++;
      if (got.is_auth) auth_lines++;
      if (expected_lines.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= ShownMismatches) begin
            $display("[%0t] line result with none expected: %s", $realtime, show_line(got));
         end
      end else begin
         want = expected_lines.pop_front();
         wrong = (got.line_valid !== want.line_valid)
               || (got.reply_code !== want.reply_code)
               || (got.separator_kind !== want.separator_kind)
               || (got.is_auth !== want.is_auth)
               || (got.message_offset !== want.message_offset)
               || (got.content_length !== want.content_length)
               || (got.total_length !== want.total_length);
         if (wrong) begin
            mismatch_count++;
            if (mismatch_count <= ShownMismatches) begin
               $display("[%0t] line %0d mismatch", $realtime, lines_checked);
               $display("   expected %s", show_line(want));
               $display("   actual   %s", show_line(got));
            end
         end
      end
   endtask

   // result side: check beats, random stall and one long hold-off
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) check_line();
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_request && !hold_done) begin
         rsp_stall <= 1'b1;
         hold_left <= HoldCycles;
         hold_done <= 1'b1;
      end else begin
         rsp_stall <= !steady && ($urandom_range(99) < IdlePercent);
      end
   end

   // run watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("timeout after %0d cycles, %0d line results still due",
                  cycle_count, expected_lines.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // stimulus
   initial begin
      script_row_type row;
      int count;
      int random_sent;
      int line_no;
      logic [7:0] ch;
      clear_line_state();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed lines
      add_row("250 AUTH PLAIN\015\n", NoTail, 0, 1, 250, SEP_SPACE, 1, 4, 14, 16);
      add_row("250-auth x\n", NoTail, 0, 1, 250, SEP_DASH, 1, 4, 10, 11);
      add_row("999 Auth\n", NoTail, 0, 1, 999, SEP_SPACE, 0, 4, 8, 9);
      add_row("000\n", NoTail, 0, 1, 0, SEP_NONE, 0, 3, 3, 4);
      add_row("1234 x\n", NoTail, 0, 0, 123, SEP_NONE, 0, 0, 6, 7);
      add_row("2a0 x\n", NoTail, 0, 0, 2, SEP_NONE, 0, 0, 5, 6);
      add_row("\015\n", NoTail, 0, 1, 0, SEP_NONE, 0, 0, 0, 2);
      add_row("25\015x\n", NoTail, 0, 0, 25, SEP_NONE, 0, 0, 4, 5);
      add_row("2\015", NoTail, 1, 0, 2, SEP_NONE, 0, 0, 2, 2);
      add_row("\015\015\n", NoTail, 0, 0, 0, SEP_NONE, 0, 0, 1, 3);
      add_row("\n", NoTail, 0, 1, 0, SEP_NONE, 0, 0, 0, 1);
      add_row("220 ok", NoTail, 1, 1, 220, SEP_SPACE, 0, 4, 6, 6);
      add_row("9\377 x\n", NoTail, 0, 0, 9, SEP_NONE, 0, 0, 4, 5);
      add_row("7", 8'h00, 1, 0, 7, SEP_NONE, 0, 0, 2, 2);
      add_row("5-\n", NoTail, 0, 1, 5, SEP_DASH, 0, 2, 2, 3);
      add_row("-AUTH \n", NoTail, 0, 1, 0, SEP_DASH, 1, 1, 6, 7);
      add_plain("354 AUTH\015\n", 0);
      add_plain("421-aUtH LOGIN\015\n", 0);
      add_plain("12 \n", 0);
      add_plain("250 AUTX y\015\n", 0);
      add_plain("5555\n", 0);

      foreach (script[r]) begin
         row = script[r];
         count = row.text.len() + ((row.tail >= 0) ? 1 : 0);
         for (int i = 0; i < count; i++) begin
            ch = (i < row.text.len()) ? row.text[i] : row.tail[7:0];
            send_byte(ch, row.eos && i == count - 1, row.typed && i == count - 1, row.want);
         end
      end

      // random lines; the long cut line does not count toward the byte budget
      random_sent = 0;
      line_no = 0;
      while (random_sent < RandomBytes) begin
         compose_reply(line_no);
         steady = (line_no >= SteadyFirst && line_no <= SteadyLast);
         if (line_no == HoldLine) hold_request = 1'b1;
         foreach (burst[k]) begin
            send_byte(burst[k].data, burst[k].last, 1'b0, '0);
         end
         if (burst.size() < LineLimit - 1) random_sent += burst.size();
         line_no++;
      end
      // close whatever line is still open
      steady = 1'b0;
      send_byte(CH_LF, 1'b0, 1'b0, '0);
      req_valid <= 1'b0;

      while (expected_lines.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      $display("run: %0d bytes in, %0d lines out (%0d invalid, %0d AUTH), %0d random lines",
               bytes_taken, lines_checked, invalid_lines, auth_lines, line_no);
      $display("covered truncation, CR and bad-code cases, long result hold-off; %0d mismatches",
               mismatch_count);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

@@ files.f @@
hdl/srlp_pkg.sv
hdl/smtp_reply_line_parser.sv
dv/testbench.sv
